FILE: sv/aabb_collide_and_step_core_macros.svh
// Assertion macros for the box collide-and-step core checker.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef AABB_COLLIDE_AND_STEP_CORE_MACROS_SVH
`define AABB_COLLIDE_AND_STEP_CORE_MACROS_SVH

// Implication in the same cycle, off during reset
`define AAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, off during reset
`define AAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checked at every edge, reset included
`define AAC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

FILE: sv/aac_pkg.sv
// Shared types, constants and helpers for the box collide-and-step core.
// No dependencies; imported by every module of the block.
`default_nettype none

package aac_pkg;

  localparam int FRAC_BITS = 8;    // Q24.8 positions, Q16.8 sizes
  localparam int DT_FRAC   = 16;   // Q0.16 frame time
  localparam int POS_W     = 32;
  localparam int SIZE_W    = 24;
  localparam int DT_W      = 16;
  localparam int EDGE_W    = POS_W + 2;  // edges and differences never wrap
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(100 << FRAC_BITS);

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_COLLIDE = 2'd1,
    REQ_STEP    = 2'd2
  } req_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHORED    = CFG_IDX_W'(2);

  // Contact sides, bit 0 is top
  typedef struct packed {
    logic right;
    logic left;
    logic bottom;
    logic top;
  } sides_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] arg_x;
    logic signed [POS_W-1:0] arg_y;
    logic [SIZE_W-1:0]       other_width;
    logic [SIZE_W-1:0]       other_height;
    logic                    other_solid;
    logic                    other_is_self;
    logic                    first_in_pass;
    logic                    last_in_pass;
    logic [DT_W-1:0]         frame_dt;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    touched;
    logic                    blocked_top;
    logic                    blocked_bottom;
    logic                    blocked_left;
    logic                    blocked_right;
  } out_item_t;

  // Collision outcome handed from the resolver to the state update
  typedef struct packed {
    logic                    hit;
    logic                    move_x;    // snap applies to x, else to y
    logic signed [POS_W-1:0] snap_pos;
    sides_t                  side;      // one-hot flag to set on a hit
  } coll_res_t;

  // Clamp a wide signed value to the position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EDGE_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v[EDGE_W-1:POS_W-1] == '0 || v[EDGE_W-1:POS_W-1] == '1) begin
      r = v[POS_W-1:0];
    end else if (v[EDGE_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/aabb_collide_and_step_core.sv
// Box collide-and-step core: own position, contact flags, config registers.
// Depends on aac_pkg, aac_in_reg, aac_collide and aac_step_axis.
//
// Use:
//   in channel (in_valid/in_ready/in_data) takes load, collide and step
//   requests; out channel (out_valid/out_ready/out_data) returns one result
//   per request: position, touched, committed contact flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes self width,
//   self height and anchored; cfg_ready is always high. Write it only while
//   no request is in flight.
// Path: a transferred request is held in the input register; its result is
//   written to the output register when that register is free.
// Throughput: one request per cycle while results are taken. The state feedback
//   (position and flags) closes through the collision resolver or the v*dt multiplier.
// Reset: position zero, flags clear, size 100.0 x 100.0, not anchored, both
//   pipeline registers empty. No clearing pass.
// Stall: a held result keeps out_data stable; the input register still takes
//   one more request, then in_ready drops until the result is taken.
`default_nettype none

module aabb_collide_and_step_core
  import aac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  logic                    item_valid;
  in_item_t                item;
  logic                    advance;
  coll_res_t               coll;
  logic signed [POS_W-1:0] step_x, step_y;

  // Config and block state
  logic [SIZE_W-1:0]       self_width, self_height;
  logic                    anchored;
  logic signed [POS_W-1:0] own_x, own_y;
  sides_t                  committed, pending;

  logic signed [POS_W-1:0] own_x_next, own_y_next;
  sides_t                  committed_next, pending_next;
  logic                    touched_next;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!out_valid || out_ready);

  aac_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  aac_collide u_collide (
    .own_x       (own_x),
    .own_y       (own_y),
    .self_width  (self_width),
    .self_height (self_height),
    .other       (item),
    .res         (coll)
  );

  aac_step_axis u_step_x (
    .pos       (own_x),
    .vel       (item.arg_x),
    .dt        (item.frame_dt),
    .block_neg (committed.left),
    .block_pos (committed.right),
    .pos_new   (step_x)
  );

  aac_step_axis u_step_y (
    .pos       (own_y),
    .vel       (item.arg_y),
    .dt        (item.frame_dt),
    .block_neg (committed.top),
    .block_pos (committed.bottom),
    .pos_new   (step_y)
  );

  // Next state for the held request
  always_comb begin
    own_x_next     = own_x;
    own_y_next     = own_y;
    pending_next   = pending;
    committed_next = committed;
    touched_next   = 1'b0;
    case (item.req_type)
      REQ_LOAD: begin
        own_x_next = item.arg_x;
        own_y_next = item.arg_y;
      end
      REQ_COLLIDE: begin
        if (!anchored) begin
          if (item.first_in_pass) begin
            pending_next = '0;
          end
          if (coll.hit) begin
            touched_next = 1'b1;
            pending_next = pending_next | coll.side;
            if (coll.move_x) begin
              own_x_next = coll.snap_pos;
            end else begin
              own_y_next = coll.snap_pos;
            end
          end
          if (item.last_in_pass) begin
            committed_next = pending_next;
          end
        end
      end
      REQ_STEP: begin
        if (!anchored) begin
          own_x_next = step_x;
          own_y_next = step_y;
        end
      end
      default: ;
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      self_width  <= SIZE_RESET;
      self_height <= SIZE_RESET;
      anchored    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SELF_WIDTH:  self_width  <= cfg_data;
        CFG_SELF_HEIGHT: self_height <= cfg_data;
        CFG_ANCHORED:    anchored    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Block state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      own_x     <= '0;
      own_y     <= '0;
      committed <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        own_x     <= own_x_next;
        own_y     <= own_y_next;
        committed <= committed_next;
        pending   <= pending_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.pos_x          <= own_x_next;
      out_data.pos_y          <= own_y_next;
      out_data.touched        <= touched_next;
      out_data.blocked_top    <= committed_next.top;
      out_data.blocked_bottom <= committed_next.bottom;
      out_data.blocked_left   <= committed_next.left;
      out_data.blocked_right  <= committed_next.right;
    end
  end

endmodule

`default_nettype wire

FILE: sv/aac_in_reg.sv
// Input register of the box core: holds one accepted item for the resolve stage.
// Depends on aac_pkg for the input item type.
`default_nettype none

module aac_in_reg
  import aac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     advance,     // held item moves to the result register
  output logic          item_valid,
  output in_item_t      item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/aac_collide.sv
// Collision resolver: inclusive overlap test and least-penetration snap choice.
// Depends on aac_pkg for sizes, the result struct and saturation.
`default_nettype none

module aac_collide
  import aac_pkg::*;
(
  input  wire logic signed [POS_W-1:0] own_x,
  input  wire logic signed [POS_W-1:0] own_y,
  input  wire logic [SIZE_W-1:0]       self_width,
  input  wire logic [SIZE_W-1:0]       self_height,
  input  wire in_item_t                other,
  output coll_res_t                    res
);

  localparam int PAD = EDGE_W - SIZE_W;

  logic signed [EDGE_W-1:0] sw, sh, ow, oh;
  logic signed [EDGE_W-1:0] ax1, ax2, ay1, ay2;
  logic signed [EDGE_W-1:0] bx1, bx2, by1, by2;
  logic signed [EDGE_W-1:0] jr, jl, jt, jb;
  logic [EDGE_W-2:0]        mr, ml, mt, mb;
  logic                     overlap;
  logic                     pick_r, pick_l, pick_t;

  // Box edges, wide enough never to wrap
  assign sw  = signed'({{PAD{1'b0}}, self_width});
  assign sh  = signed'({{PAD{1'b0}}, self_height});
  assign ow  = signed'({{PAD{1'b0}}, other.other_width});
  assign oh  = signed'({{PAD{1'b0}}, other.other_height});
  assign ax1 = EDGE_W'(own_x);
  assign ay1 = EDGE_W'(own_y);
  assign ax2 = ax1 + sw;
  assign ay2 = ay1 + sh;
  assign bx1 = EDGE_W'(other.arg_x);
  assign by1 = EDGE_W'(other.arg_y);
  assign bx2 = bx1 + ow;
  assign by2 = by1 + oh;

  // Penetration depths; all non-negative exactly when the boxes overlap
  assign jr = bx2 - ax1;   // push right, contact on left
  assign jl = ax2 - bx1;   // push left, contact on right
  assign jt = ay2 - by1;   // push up, contact on bottom
  assign jb = by2 - ay1;   // push down, contact on top

  assign overlap = !jr[EDGE_W-1] && !jl[EDGE_W-1] && !jt[EDGE_W-1] && !jb[EDGE_W-1];

  assign mr = jr[EDGE_W-2:0];
  assign ml = jl[EDGE_W-2:0];
  assign mt = jt[EDGE_W-2:0];
  assign mb = jb[EDGE_W-2:0];

  // Least depth wins; ties resolve right, left, up, down
  assign pick_r = (mr <= ml) && (mr <= mt) && (mr <= mb);
  assign pick_l = (ml <= mt) && (ml <= mb);
  assign pick_t = (mt <= mb);

  always_comb begin
    res.hit    = other.other_solid && !other.other_is_self && overlap;
    res.side   = '0;
    res.move_x = 1'b0;
    if (pick_r) begin
      res.move_x     = 1'b1;
      res.snap_pos   = sat_pos(bx2);
      res.side.left  = 1'b1;
    end else if (pick_l) begin
      res.move_x     = 1'b1;
      res.snap_pos   = sat_pos(bx1 - sw);
      res.side.right = 1'b1;
    end else if (pick_t) begin
      res.snap_pos    = sat_pos(by1 - sh);
      res.side.bottom = 1'b1;
    end else begin
      res.snap_pos = sat_pos(by2);
      res.side.top = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/aac_step_axis.sv
// One axis of the physics step: blocked-side velocity cut, v*dt rounding, saturating add.
// Depends on aac_pkg for widths, the dt format and saturation.
`default_nettype none

module aac_step_axis
  import aac_pkg::*;
(
  input  wire logic signed [POS_W-1:0] pos,
  input  wire logic signed [POS_W-1:0] vel,
  input  wire logic [DT_W-1:0]         dt,
  input  wire logic                    block_neg,  // contact on the low side
  input  wire logic                    block_pos,  // contact on the high side
  output logic signed [POS_W-1:0]      pos_new
);

  localparam int PROD_W = POS_W + DT_W + 1;

  logic signed [POS_W-1:0]  vel_eff;
  logic signed [DT_W:0]     dt_s;
  logic signed [PROD_W-1:0] prod, rnd;
  logic signed [POS_W:0]    delta;
  logic signed [EDGE_W-1:0] sum;

  // No motion into a side that is in contact
  always_comb begin
    vel_eff = vel;
    if ((block_neg && vel[POS_W-1]) || (block_pos && !vel[POS_W-1] && vel != '0)) begin
      vel_eff = '0;
    end
  end

  // Round half up to Q24.8, then add with saturation
  assign dt_s    = signed'({1'b0, dt});
  assign prod    = PROD_W'(vel_eff) * PROD_W'(dt_s);
  assign rnd     = prod + PROD_W'(1 << (DT_FRAC - 1));
  assign delta   = rnd[PROD_W-1:DT_FRAC];
  assign sum     = EDGE_W'(pos) + EDGE_W'(delta);
  assign pos_new = sat_pos(sum);

endmodule

`default_nettype wire

FILE: sv/aac_checker.sv
// Port-level checker for the box collide-and-step core, bound to the top level.
// Depends on aac_pkg and aabb_collide_and_step_core_macros.svh.
`default_nettype none
`include "aabb_collide_and_step_core_macros.svh"

module aac_checker
  import aac_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result holds
  `AAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Output register is empty right after reset; no history yet at the first edge
  `AAC_ASSERT_ALWAYS(a_reset_empty, $past(rst) !== 1'b1 || !out_valid, "result valid after reset")

  // Input side never stalls while the output side can drain
  `AAC_ASSERT_IMPL(a_no_stall, !out_valid || out_ready, in_ready, "input blocked with free output")

  // A fresh result comes from a transfer that passed the input register, then the output register
  `AAC_ASSERT_IMPL(a_rise_src, $rose(out_valid), $past(in_valid && in_ready, 2), "result without request")

endmodule

bind aabb_collide_and_step_core aac_checker u_aac_checker (.*);

`default_nettype wire
